@@ design/cte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_pkg
// Shared constants, types and the month table for the calendar to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package cte_pkg;

    // register stages between the input and the output transfer
    localparam int NSTAGES = 6;

    localparam logic [11:0] TWO_DIGIT_LIMIT = 12'd69;
    localparam logic [12:0] CENTURY_BASE    = 13'd2000;
    localparam logic [12:0] EPOCH_YEAR      = 13'd1970;
    localparam logic [12:0] LAST_YEAR       = 13'd2099;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 4096
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_SHIFT     = 19;

    // leap days in years 1..1969
    localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd477;

    localparam logic signed [20:0] DAYS_PER_YEAR = 21'sd365;
    localparam logic signed [18:0] SECS_PER_HOUR = 19'sd3600;
    localparam logic signed [32:0] SECS_PER_DAY  = 33'sd86400;

    typedef struct packed {
        logic [NSTAGES-1:0] load;   // stage register takes its next value
        logic [NSTAGES-1:0] valid;  // stage holds a live item
    } cte_ctrl_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

@@ design/cte_pipe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_pipe_ctrl
// Valid tracking and per-stage load enables for the converter pipeline.
// A stage loads when it is empty or its successor loads, so bubbles close
// up behind a stalled output.
// ----------------------------------------------------------------------------
module cte_pipe_ctrl
    import cte_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    output cte_ctrl_t ctrl
);

    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] valid_next;
    logic [NSTAGES-1:0] load;

    always_comb begin
        load[NSTAGES-1] = out_ready | ~valid_reg[NSTAGES-1];
        for (int k = NSTAGES - 2; k >= 0; k--) begin
            load[k] = load[k+1] | ~valid_reg[k];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NSTAGES; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = load[0];
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule

@@ design/calendar_to_epoch_seconds.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Converts a calendar date and time to seconds since 1970-01-01 00:00:00,
// less a configured zone offset in hours.
// ----------------------------------------------------------------------------
// Throughput is one transfer per cycle while m_ready is high. The six
// register stages are: year fold and time of day prep; the constant
// multiplies (year/100 reciprocals, (year-1970)*365, hour*3600); leap
// test and day-of-year sum; total days; days*86400; final add. Each
// stage advances on its own, so a stalled output only holds items behind
// it until the empty stages fill. Years below 69 read as 20xx. The zone
// register is sampled as items pass, so write it only while the block is
// drained.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds
    import cte_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic signed [4:0]  cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_year_in,
    input  logic [3:0]         s_month_index,
    input  logic [4:0]         s_day_of_month,
    input  logic [4:0]         s_hour_in,
    input  logic [5:0]         s_minute_in,
    input  logic [5:0]         s_second_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [32:0] m_epoch_seconds,
    output logic               m_year_out_of_range
);

    cte_ctrl_t ctrl;

    logic signed [4:0] zone_reg;

    // stage 1
    logic [12:0]       s1_year_reg,  s1_year_next;
    logic [3:0]        s1_month_reg, s1_month_next;
    logic [4:0]        s1_day_reg;
    logic signed [6:0] s1_hz_reg,    s1_hz_next;
    logic [11:0]       s1_ms_reg,    s1_ms_next;
    logic              s1_oor_reg,   s1_oor_next;
    // stage 2
    logic [12:0]        ym1;
    logic [12:0]        s2_year_reg;
    logic [9:0]         s2_q4_reg;
    logic [24:0]        s2_p100_reg, s2_p100_next;
    logic [22:0]        s2_p400_reg, s2_p400_next;
    logic [24:0]        s2_py_reg,   s2_py_next;
    logic signed [13:0] ydiff;
    logic signed [20:0] s2_ydays_reg, s2_ydays_next;
    logic signed [18:0] s2_tod_reg,   s2_tod_next;
    logic [8:0]         s2_dbm_reg;
    logic               s2_after_feb_reg;
    logic [4:0]         s2_day_reg;
    logic               s2_oor_reg;
    // stage 3
    logic [5:0]         d100, ycent;
    logic [3:0]         d400;
    logic               leap;
    logic [11:0]        adj_sum;
    logic signed [11:0] s3_adj_reg;
    logic signed [20:0] s3_ydays_reg;
    logic signed [18:0] s3_tod_reg;
    logic               s3_oor_reg;
    // stage 4
    logic signed [20:0] s4_days_reg, s4_days_next;
    logic signed [18:0] s4_tod_reg;
    logic               s4_oor_reg;
    // stage 5
    logic signed [32:0] s5_dsec_reg, s5_dsec_next;
    logic signed [18:0] s5_tod_reg;
    logic               s5_oor_reg;
    // stage 6
    logic signed [32:0] s6_secs_reg, s6_secs_next;
    logic               s6_oor_reg;

    cte_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_ready (m_ready),
        .ctrl      (ctrl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg <= '0;
        end else if (cfg_we) begin
            zone_reg <= cfg_wdata;
        end
    end

    // ---- stage 1: year fold, month clamp, time of day parts
    always_comb begin
        if (s_year_in < TWO_DIGIT_LIMIT) begin
            s1_year_next = 13'(s_year_in) + CENTURY_BASE;
        end else begin
            s1_year_next = 13'(s_year_in);
        end
        s1_month_next = (s_month_index > 4'd11) ? 4'd11 : s_month_index;
        s1_oor_next   = (s1_year_next < EPOCH_YEAR) || (s1_year_next > LAST_YEAR);
        s1_hz_next    = $signed({2'b00, s_hour_in}) - 7'(zone_reg);
        s1_ms_next    = 12'(s_minute_in) * 12'd60 + 12'(s_second_in);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            s1_year_reg  <= s1_year_next;
            s1_month_reg <= s1_month_next;
            s1_day_reg   <= s_day_of_month;
            s1_hz_reg    <= s1_hz_next;
            s1_ms_reg    <= s1_ms_next;
            s1_oor_reg   <= s1_oor_next;
        end
    end

    // ---- stage 2: constant multiplies
    always_comb begin
        ym1           = s1_year_reg - 13'd1;
        s2_p100_next  = 25'(ym1) * 25'(RECIP_100);
        s2_p400_next  = 23'(ym1[11:2]) * 23'(RECIP_100);
        s2_py_next    = 25'(s1_year_reg) * 25'(RECIP_100);
        ydiff         = $signed({1'b0, s1_year_reg}) - $signed({1'b0, EPOCH_YEAR});
        s2_ydays_next = 21'(ydiff) * DAYS_PER_YEAR;
        s2_tod_next   = 19'(s1_hz_reg) * SECS_PER_HOUR + $signed({7'b0, s1_ms_reg});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            s2_year_reg      <= s1_year_reg;
            s2_q4_reg        <= ym1[11:2];
            s2_p100_reg      <= s2_p100_next;
            s2_p400_reg      <= s2_p400_next;
            s2_py_reg        <= s2_py_next;
            s2_ydays_reg     <= s2_ydays_next;
            s2_tod_reg       <= s2_tod_next;
            s2_dbm_reg       <= days_before_month(s1_month_reg);
            s2_after_feb_reg <= (s1_month_reg > 4'd1);
            s2_day_reg       <= s1_day_reg;
            s2_oor_reg       <= s1_oor_reg;
        end
    end

    // ---- stage 3: leap test, leap days since epoch, day within year
    always_comb begin
        d100  = s2_p100_reg[RECIP_SHIFT +: 6];
        d400  = s2_p400_reg[RECIP_SHIFT +: 4];
        ycent = s2_py_reg[RECIP_SHIFT +: 6];
        // century years are leap only when the century divides by four
        leap  = (s2_year_reg[1:0] == 2'b00)
              && ((13'(ycent) * 13'd100 != s2_year_reg) || (ycent[1:0] == 2'b00));
        adj_sum = 12'(s2_q4_reg) - 12'(d100) + 12'(d400) - LEAPS_BEFORE_EPOCH
                + 12'(s2_dbm_reg) + 12'(leap && s2_after_feb_reg)
                + 12'(s2_day_reg) - 12'd1;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            s3_adj_reg   <= $signed(adj_sum);
            s3_ydays_reg <= s2_ydays_reg;
            s3_tod_reg   <= s2_tod_reg;
            s3_oor_reg   <= s2_oor_reg;
        end
    end

    // ---- stage 4: total days
    assign s4_days_next = s3_ydays_reg + 21'(s3_adj_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            s4_days_reg <= s4_days_next;
            s4_tod_reg  <= s3_tod_reg;
            s4_oor_reg  <= s3_oor_reg;
        end
    end

    // ---- stage 5: days to seconds, kept modulo 2^33
    assign s5_dsec_next = 33'(s4_days_reg) * SECS_PER_DAY;

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            s5_dsec_reg <= s5_dsec_next;
            s5_tod_reg  <= s4_tod_reg;
            s5_oor_reg  <= s4_oor_reg;
        end
    end

    // ---- stage 6: add time of day, output register
    assign s6_secs_next = s5_dsec_reg + 33'(s5_tod_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.load[5]) begin
            s6_secs_reg <= s6_secs_next;
            s6_oor_reg  <= s5_oor_reg;
        end
    end

    assign m_valid             = ctrl.valid[NSTAGES-1];
    assign m_epoch_seconds     = s6_secs_reg;
    assign m_year_out_of_range = s6_oor_reg;

endmodule

@@ design/cte_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_port_checks
// Port-level checks for the converter: output hold under stall, reset
// behavior, and transfer accounting against the pipeline depth.
// ----------------------------------------------------------------------------
module cte_port_checks
    import cte_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [32:0] m_epoch_seconds,
    input logic               m_year_out_of_range
);

    // items accepted but not yet delivered
    logic [3:0] inflight_reg, inflight_next;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_valid && s_ready) begin
            inflight_next = inflight_next + 4'd1;
        end
        if (m_valid && m_ready) begin
            inflight_next = inflight_next - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_epoch_seconds)
            && $stable(m_year_out_of_range))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 4'd0)
        else $error("result with no item in flight");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 4'(NSTAGES))
        else $error("more items in flight than stages");

    a_ready_when_empty_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output is free");

endmodule

bind calendar_to_epoch_seconds cte_port_checks u_cte_port_checks (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_epoch_seconds     (m_epoch_seconds),
    .m_year_out_of_range (m_year_out_of_range)
);
